### hdl/sps_pkg.sv
// shared types, codes and helpers for the shape pair overlap test
package sps_pkg;

  localparam logic [1:0] KIND_AXIS_BOX     = 2'd0;
  localparam logic [1:0] KIND_ORIENTED_BOX = 2'd1;
  localparam logic [1:0] KIND_CIRCLE       = 2'd2;
  localparam logic [1:0] KIND_UNUSED       = 2'd3;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // operand width of the squaring unit and width of its result
  localparam int SQ_IN_W  = 47;
  localparam int SQ_OUT_W = 2 * SQ_IN_W;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_CC,
    MODE_CB,
    MODE_BB
  } mode_t;

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
  } frame_t;

  typedef logic [SQ_IN_W-1:0]  sq_in_t;
  typedef logic [SQ_OUT_W-1:0] sq_out_t;

  function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] a);
    logic signed [15:0] r;
    r = a;
    if (a > ONE_Q14) r = ONE_Q14;
    else if (a < -ONE_Q14) r = -ONE_Q14;
    return r;
  endfunction

  function automatic frame_t make_frame(input logic [1:0] kind,
                                        input logic signed [15:0] c,
                                        input logic signed [15:0] s);
    frame_t f;
    if (kind == KIND_AXIS_BOX) begin
      f.rx = ONE_Q14;
      f.ry = '0;
      f.ux = '0;
      f.uy = ONE_Q14;
    end else begin
      f.rx = c;
      f.ry = s;
      f.ux = -s;
      f.uy = c;
    end
    return f;
  endfunction

endpackage

### hdl/shape_pair_overlap_test.sv
// shape pair overlap test: box/box by separating axes, circle/box, circle/circle
//
//   channel | dir | ports                          | beat
//   in      | in  | in_tvalid in_tready in_tdata   | one shape pair (256 bits)
//   out     | out | out_tvalid out_tready out_tdata| overlap flag (8 bits)
//
// six register stages from accept to result beat; one beat per cycle sustained
// if out_tready is high; the depth is set by the axis dot products, the extent
// products and the split 47-bit squares that feed the 95-bit radius compare
// rst_n clears every valid bit; payload registers are not reset
// the whole pipeline holds while a result waits on out_tready, so nothing is
// lost or repeated; in_tready follows that same hold
module shape_pair_overlap_test
  import sps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // shape_one[1:0] shape_two[3:2] offset_x[35:4] offset_y[67:36]
  // size_one_x[98:68] size_one_y[129:99] size_two_x[160:130] size_two_y[191:161]
  // axis_one_cos[207:192] axis_one_sin[223:208] axis_two_cos[239:224]
  // axis_two_sin[255:240]
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // overlap[0], zero fill above
  output logic [7:0]   out_tdata
);

  logic en;
  logic out_tvalid_r;
  logic overlap_r;

  // pipeline advances whenever the result register can take a beat
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: unpack, clamp, frames, case select
  logic [1:0]         k1, k2;
  logic signed [31:0] ox, oy;
  logic [30:0]        s1x, s1y, s2x, s2y;
  logic signed [15:0] c1, n1, c2, n2;
  frame_t             f1, f2;
  mode_t              mode_nxt;
  logic [31:0]        oxm, oym;
  logic [31:0]        rsum;

  assign k1  = in_tdata[1:0];
  assign k2  = in_tdata[3:2];
  assign ox  = in_tdata[35:4];
  assign oy  = in_tdata[67:36];
  assign s1x = in_tdata[98:68];
  assign s1y = in_tdata[129:99];
  assign s2x = in_tdata[160:130];
  assign s2y = in_tdata[191:161];
  assign c1  = clamp_axis(in_tdata[207:192]);
  assign n1  = clamp_axis(in_tdata[223:208]);
  assign c2  = clamp_axis(in_tdata[239:224]);
  assign n2  = clamp_axis(in_tdata[255:240]);
  assign f1  = make_frame(k1, c1, n1);
  assign f2  = make_frame(k2, c2, n2);
  assign oxm = ox[31] ? 32'(-ox) : 32'(ox);
  assign oym = oy[31] ? 32'(-oy) : 32'(oy);
  assign rsum = 32'(s1x) + 32'(s2x);

  always_comb begin
    if (k1 == KIND_UNUSED || k2 == KIND_UNUSED) mode_nxt = MODE_NONE;
    else if (k1 == KIND_CIRCLE && k2 == KIND_CIRCLE) mode_nxt = MODE_CC;
    else if (k1 == KIND_CIRCLE || k2 == KIND_CIRCLE) mode_nxt = MODE_CB;
    else mode_nxt = MODE_BB;
  end

  logic               v1_r;
  mode_t              mode1_r;
  frame_t             fa1_r, fb1_r, cf1_r;
  logic [30:0]        wa1_r, ha1_r, wb1_r, hb1_r, cw1_r, ch1_r;
  logic signed [31:0] dx1_r, dy1_r;
  logic signed [32:0] cvx1_r, cvy1_r;
  sq_in_t             ccr1_r, cca1_r, ccb1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= mode_nxt;
      fa1_r   <= f1;
      fb1_r   <= f2;
      wa1_r   <= s1x;
      ha1_r   <= s1y;
      wb1_r   <= s2x;
      hb1_r   <= s2y;
      dx1_r   <= ox;
      dy1_r   <= oy;
      // circle against box: box frame, circle centre in that frame's origin
      if (k1 == KIND_CIRCLE) begin
        cf1_r  <= f2;
        cw1_r  <= s2x;
        ch1_r  <= s2y;
        cvx1_r <= -33'(ox);
        cvy1_r <= -33'(oy);
      end else begin
        cf1_r  <= f1;
        cw1_r  <= s1x;
        ch1_r  <= s1y;
        cvx1_r <= 33'(ox);
        cvy1_r <= 33'(oy);
      end
      // circle pair compares against the summed radii
      if (mode_nxt == MODE_CC) ccr1_r <= {1'b0, rsum, 14'b0};
      else if (k1 == KIND_CIRCLE) ccr1_r <= {2'b0, s1x, 14'b0};
      else ccr1_r <= {2'b0, s2x, 14'b0};
      // circle pair scaled by 2^14 so it shares the square compare
      cca1_r <= {1'b0, oxm, 14'b0};
      ccb1_r <= {1'b0, oym, 14'b0};
    end
  end

  // ---------------- stage 2: dot products on the four axes and circle frame
  function automatic logic [29:0] pmag(input logic signed [15:0] p, q, x, y);
    logic signed [31:0] s;
    s = p * x + q * y;
    return s[31] ? 30'(-s) : 30'(s);
  endfunction

  function automatic logic [46:0] cmag(input logic signed [32:0] a, b,
                                       input logic signed [15:0] x, y);
    logic signed [48:0] s;
    s = a * x + b * y;
    return s[48] ? 47'(-s) : 47'(s);
  endfunction

  logic signed [15:0] ax [4];
  logic signed [15:0] ay [4];

  assign ax[0] = fa1_r.rx;  assign ay[0] = fa1_r.ry;
  assign ax[1] = fa1_r.ux;  assign ay[1] = fa1_r.uy;
  assign ax[2] = fb1_r.rx;  assign ay[2] = fb1_r.ry;
  assign ax[3] = fb1_r.ux;  assign ay[3] = fb1_r.uy;

  logic        v2_r;
  mode_t       mode2_r;
  logic [46:0] cd2_r [4];
  logic [29:0] par2_r [4], pau2_r [4], pbr2_r [4], pbu2_r [4];
  logic [30:0] wa2_r, ha2_r, wb2_r, hb2_r, cw2_r, ch2_r;
  logic [46:0] lx2_r, ly2_r;
  sq_in_t      ccr2_r, cca2_r, ccb2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        cd2_r[k]  <= cmag(33'(dx1_r), 33'(dy1_r), ax[k], ay[k]);
        par2_r[k] <= pmag(fa1_r.rx, fa1_r.ry, ax[k], ay[k]);
        pau2_r[k] <= pmag(fa1_r.ux, fa1_r.uy, ax[k], ay[k]);
        pbr2_r[k] <= pmag(fb1_r.rx, fb1_r.ry, ax[k], ay[k]);
        pbu2_r[k] <= pmag(fb1_r.ux, fb1_r.uy, ax[k], ay[k]);
      end
      mode2_r <= mode1_r;
      wa2_r   <= wa1_r;
      ha2_r   <= ha1_r;
      wb2_r   <= wb1_r;
      hb2_r   <= hb1_r;
      cw2_r   <= cw1_r;
      ch2_r   <= ch1_r;
      lx2_r   <= cmag(cvx1_r, cvy1_r, cf1_r.rx, cf1_r.ry);
      ly2_r   <= cmag(cvx1_r, cvy1_r, cf1_r.ux, cf1_r.uy);
      ccr2_r  <= ccr1_r;
      cca2_r  <= cca1_r;
      ccb2_r  <= ccb1_r;
    end
  end

  // ---------------- stage 3: extents, centre distances, clamp to the box
  logic [46:0] bx, by;
  logic [46:0] ex, ey;

  assign bx = 47'({cw2_r, 13'b0});
  assign by = 47'({ch2_r, 13'b0});
  assign ex = (lx2_r > bx) ? lx2_r - bx : '0;
  assign ey = (ly2_r > by) ? ly2_r - by : '0;

  logic        v3_r;
  mode_t       mode3_r;
  logic [62:0] ext3_r [4];
  logic [61:0] cen3_r [4];
  sq_in_t      sqa3_r, sqb3_r, sqr3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ext3_r[k] <= 63'(par2_r[k]) * 63'(wa2_r) + 63'(pau2_r[k]) * 63'(ha2_r)
                   + 63'(pbr2_r[k]) * 63'(wb2_r) + 63'(pbu2_r[k]) * 63'(hb2_r);
        cen3_r[k] <= {cd2_r[k], 15'b0};
      end
      mode3_r <= mode2_r;
      sqr3_r  <= ccr2_r;
      if (mode2_r == MODE_CC) begin
        sqa3_r <= cca2_r;
        sqb3_r <= ccb2_r;
      end else begin
        sqa3_r <= ex;
        sqb3_r <= ey;
      end
    end
  end

  // ---------------- stages 4 and 5: axis compares and the squares
  sq_out_t sqa, sqb, sqr;

  sps_square u_sq_a (.clk(clk), .en(en), .a(sqa3_r), .sq(sqa));
  sps_square u_sq_b (.clk(clk), .en(en), .a(sqb3_r), .sq(sqb));
  sps_square u_sq_r (.clk(clk), .en(en), .a(sqr3_r), .sq(sqr));

  logic        v4_r, v5_r;
  mode_t       mode4_r, mode5_r;
  logic        bb4_r, bb5_r;
  logic        bb_nxt;

  // touching counts as a hit on every axis
  always_comb begin
    bb_nxt = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (63'(cen3_r[k]) > ext3_r[k]) bb_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode4_r <= mode3_r;
      bb4_r   <= bb_nxt;
      mode5_r <= mode4_r;
      bb5_r   <= bb4_r;
    end
  end

  // ---------------- stage 6: final decision into the result register
  logic [SQ_OUT_W:0] sum5;
  logic              overlap_nxt;

  assign sum5 = (SQ_OUT_W + 1)'(sqa) + (SQ_OUT_W + 1)'(sqb);

  always_comb begin
    case (mode5_r)
      MODE_BB: overlap_nxt = bb5_r;
      MODE_CC,
      MODE_CB: overlap_nxt = sum5 < (SQ_OUT_W + 1)'(sqr);
      default: overlap_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) overlap_r <= overlap_nxt;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r         <= in_tvalid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      out_tvalid_r <= v5_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, overlap_r};

  // ---------------- checks
  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted beat did not enter stage one");

  a_stall_keeps : assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en |=> v3_r && $stable(mode3_r))
    else $error("stalled beat lost in stage three");

  a_bad_kind : assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && en && mode5_r == MODE_NONE |=> out_tvalid && !out_tdata[0])
    else $error("unused shape kind reported an overlap");

endmodule

### hdl/sps_square.sv
// two-stage squaring unit built from three narrow partial products
module sps_square
  import sps_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  sq_in_t  a,
  output sq_out_t sq
);

  localparam int LO_W = SQ_IN_W / 2;
  localparam int HI_W = SQ_IN_W - LO_W;

  logic [HI_W-1:0]      hi;
  logic [LO_W-1:0]      lo;
  logic [2*HI_W-1:0]    pp_hh_r;
  logic [HI_W+LO_W-1:0] pp_hl_r;
  logic [2*LO_W-1:0]    pp_ll_r;
  sq_out_t              sq_r;

  assign hi = a[SQ_IN_W-1:LO_W];
  assign lo = a[LO_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r <= hi * hi;
      pp_hl_r <= hi * lo;
      pp_ll_r <= lo * lo;
      sq_r    <= (SQ_OUT_W'(pp_hh_r) << (2 * LO_W))
               + (SQ_OUT_W'(pp_hl_r) << (LO_W + 1))
               + SQ_OUT_W'(pp_ll_r);
    end
  end

  assign sq = sq_r;

endmodule
